/* rtl/asfc_pkg.sv */
// Package for the angle sensor frame checker: item types, register codes,
// CRC-8 constants and the parallel CRC function. No dependencies.
package asfc_pkg;

  localparam int WORD_W      = 16;
  localparam int ANGLE_W     = 15;
  localparam int COUNT_W     = 16;
  localparam int RATE_W      = COUNT_W + 1;
  localparam int CRC_W       = 8;
  localparam int CFG_ADDR_W  = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_FAULT_LIMIT  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_FAULT_ENABLE = CFG_ADDR_W'(1);

  localparam logic [COUNT_W-1:0] FAULT_LIMIT_RESET = COUNT_W'(1000);
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  localparam logic [3:0]       STATUS_OK  = 4'hF;
  localparam logic [CRC_W-1:0] CRC_POLY   = 8'h1D;
  localparam logic [CRC_W-1:0] CRC_INIT   = 8'hFF;
  localparam logic [CRC_W-1:0] CRC_XOROUT = 8'hFF;

  localparam int MSG_W = 2 * WORD_W;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] angle_word;
    logic [WORD_W-1:0] safety_word;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               angle_valid;
    logic               status_error;
    logic               crc_error;
    logic [RATE_W-1:0]  error_rate;
    logic               data_fault;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Bit-serial CRC, MSB first. Used only at elaboration to build constants.
  function automatic logic [CRC_W-1:0] crc_serial(input logic [MSG_W-1:0] msg,
                                                  input logic [CRC_W-1:0] init);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = init;
    for (int i = MSG_W - 1; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ msg[i];
      r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return r;
  endfunction

  // Contribution of each message bit, with zero initial value.
  function automatic logic [MSG_W-1:0][CRC_W-1:0] crc_cols_gen();
    logic [MSG_W-1:0][CRC_W-1:0] cols;
    for (int i = 0; i < MSG_W; i++) begin
      cols[i] = crc_serial(MSG_W'(1) << i, '0);
    end
    return cols;
  endfunction

  localparam logic [MSG_W-1:0][CRC_W-1:0] CRC_COLS = crc_cols_gen();
  // CRC of an all-zero message, with the initial value and final xor folded in.
  localparam logic [CRC_W-1:0] CRC_BASE = crc_serial('0, CRC_INIT) ^ CRC_XOROUT;

  // The CRC is linear in the message, so each bit adds its column independently.
  function automatic logic [CRC_W-1:0] crc8_frame(input logic [MSG_W-1:0] msg);
    logic [CRC_W-1:0] acc;
    acc = CRC_BASE;
    for (int i = 0; i < MSG_W; i++) begin
      acc ^= msg[i] ? CRC_COLS[i] : '0;
    end
    return acc;
  endfunction

endpackage

/* rtl/asfc_chan_if.sv */
// Valid/ready channel interface carrying one item of a given payload type.
// Depends on nothing; payload types come from asfc_pkg at the instance.
interface asfc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/angle_sensor_frame_checker.sv */
// Top level of the angle sensor frame checker: input register, check logic,
// error counters and result register. Uses asfc_pkg and asfc_chan_if.
//
// Usage:
//   frame_in carries one item per sensor frame (cmd = frame) or one window
//   tick (cmd = tick). result_out returns exactly one item for each input
//   item, in order. cfg writes fault_limit (index 0) and fault_enable
//   (index 1); writes to other indexes are accepted and ignored. cfg is
//   always ready.
//   An item accepted at a clock edge sits in the input register; the CRC,
//   status check and counter update then feed the result register, which
//   drives result_out. Throughput is one item per cycle while result_out is
//   not stalled; the CRC over both words is a flat xor network, so nothing
//   iterates.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more item; only when both are full
//   does frame_in drop ready.
//   A synchronous reset clears both error counters, empties the pipeline
//   and restores fault_limit to 1000 and fault_enable to 0.
//   The counters saturate at 65535. A tick reports their sum and the fault
//   flag, then clears both counts.
module angle_sensor_frame_checker
  import asfc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  asfc_chan_if.sink   frame_in,
  asfc_chan_if.sink   cfg,
  asfc_chan_if.source result_out
);

  // Configuration registers. The port never stalls.
  logic [COUNT_W-1:0] fault_limit;
  logic               fault_enable;
  cfg_item_t          cfg_item;

  assign cfg.ready = 1'b1;
  assign cfg_item  = cfg.payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_limit  <= FAULT_LIMIT_RESET;
      fault_enable <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg_item.addr == REG_FAULT_LIMIT) begin
        fault_limit <= cfg_item.data;
      end
      if (cfg_item.addr == REG_FAULT_ENABLE) begin
        fault_enable <= cfg_item.data[0];
      end
    end
  end

  // Pipeline control. The result register loads when it is empty or being
  // drained; the input register advances whenever the result register loads.
  logic      s1_valid;
  in_item_t  s1;
  logic      out_valid;
  out_item_t out_item;
  logic      out_load;
  logic      s1_adv;
  logic      in_take;

  assign out_load       = !out_valid || result_out.ready;
  assign s1_adv         = s1_valid && out_load;
  assign frame_in.ready = !s1_valid || out_load;
  assign in_take        = frame_in.valid && frame_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_in.ready) begin
      s1_valid <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1 <= frame_in.payload;
    end
  end

  // Frame check on the registered item.
  logic [CRC_W-1:0] crc_calc;
  logic             status_ok;
  logic             crc_ok;
  logic             is_tick;

  assign crc_calc  = crc8_frame({s1.first_word, s1.angle_word});
  assign status_ok = (s1.safety_word[WORD_W-1 -: 4] == STATUS_OK);
  assign crc_ok    = (crc_calc == s1.safety_word[CRC_W-1:0]);
  assign is_tick   = (s1.cmd == CMD_TICK);

  // Error counters and the result for the item in the input register.
  logic [COUNT_W-1:0] status_count, status_count_next;
  logic [COUNT_W-1:0] crc_count, crc_count_next;
  out_item_t          result_next;

  always_comb begin
    status_count_next = status_count;
    crc_count_next    = crc_count;
    result_next       = '0;
    if (is_tick) begin
      result_next.error_rate = RATE_W'(status_count) + RATE_W'(crc_count);
      // Both counts at zero never flag, even with a limit of zero.
      result_next.data_fault = fault_enable &&
                               (status_count != '0 || crc_count != '0) &&
                               (status_count >= fault_limit ||
                                crc_count >= fault_limit);
      status_count_next = '0;
      crc_count_next    = '0;
    end else if (!status_ok) begin
      // A bad status word means the CRC is not judged at all.
      result_next.status_error = 1'b1;
      if (status_count != COUNT_MAX) begin
        status_count_next = status_count + COUNT_W'(1);
      end
    end else if (!crc_ok) begin
      result_next.crc_error = 1'b1;
      if (crc_count != COUNT_MAX) begin
        crc_count_next = crc_count + COUNT_W'(1);
      end
    end else begin
      result_next.angle       = s1.angle_word[ANGLE_W-1:0];
      result_next.angle_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_count <= '0;
      crc_count    <= '0;
    end else if (s1_adv) begin
      status_count <= status_count_next;
      crc_count    <= crc_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= result_next;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.payload = out_item;

  // A result never carries more than one of the three frame outcomes.
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_item.angle_valid, out_item.status_error,
                              out_item.crc_error}) <= 1)
    else $error("result carries more than one frame outcome");

  // A tick that leaves the input register clears both counters.
  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && is_tick) |=> (status_count == '0 && crc_count == '0))
    else $error("error counters not cleared after tick");

  // Frames only ever move the counters upward.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !is_tick) |=> (status_count >= $past(status_count) &&
                              crc_count >= $past(crc_count)))
    else $error("error counter decreased on a frame");

  // A held item in the input register must block new items.
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !frame_in.ready)
    else $error("input accepted while the input register is held");

endmodule

/* verif/tb_angle_sensor_frame_checker.sv */
// Self-checking testbench for angle_sensor_frame_checker: frame status and CRC
// checks, error counters, window ticks and data fault flagging.
// Depends on asfc_pkg, asfc_chan_if and the angle_sensor_frame_checker RTL.
module tb_angle_sensor_frame_checker;
  import asfc_pkg::*;

  localparam int CLK_HIGH        = 6;
  localparam int CLK_LOW         = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int MAX_GAP         = 7;
  localparam int CYCLE_LIMIT     = 100_000;
  localparam int TAIL_CYCLES     = 8;
  localparam int REPORT_MAX      = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 90;

  // Indexes with no register behind them. Between them they toggle every
  // address bit, and the block must accept and ignore both.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 8'hA5;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 8'h5A;

  // Kinds of failing frame that the stimulus builds.
  typedef enum logic {ERR_STATUS, ERR_CRC} err_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  asfc_chan_if #(.payload_t(in_item_t))  frame_if ();
  asfc_chan_if #(.payload_t(cfg_item_t)) cfg_if ();
  asfc_chan_if #(.payload_t(out_item_t)) result_if ();

  angle_sensor_frame_checker i_dut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_if),
    .cfg        (cfg_if),
    .result_out (result_if)
  );

  // Shadow copy of the block's registers and error counters. It is updated
  // at the clock edge where the matching item or register write is accepted,
  // so it always reflects what the block has seen so far.
  logic [COUNT_W-1:0] shadow_status_errs  = '0;
  logic [COUNT_W-1:0] shadow_crc_errs     = '0;
  logic [COUNT_W-1:0] shadow_fault_limit  = FAULT_LIMIT_RESET;
  logic               shadow_fault_enable = 1'b0;

  // Results still owed by the block, oldest first.
  out_item_t pending_results[$];

  int unsigned tx_gap_max     = 0;
  int unsigned rx_stall_max   = 0;
  int unsigned rx_hold        = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // CRC-8 with polynomial 0x1D, worked out one message bit at a time. The
  // first word goes in first, most significant bit leading.
  function automatic logic [CRC_W-1:0] sae_crc8(input logic [WORD_W-1:0] w0,
                                                input logic [WORD_W-1:0] w1);
    logic [2*WORD_W-1:0] msg;
    logic [CRC_W-1:0]    crc;
    logic                fb;
    msg = {w0, w1};
    crc = CRC_INIT;
    for (int i = 2 * WORD_W - 1; i >= 0; i--) begin
      fb  = crc[CRC_W-1] ^ msg[i];
      crc = {crc[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return crc ^ CRC_XOROUT;
  endfunction

  // Works out the result of one accepted item and moves the shadow counters
  // along. A status failure hides the CRC check; a tick reports and clears.
  task automatic predict_result(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.cmd == CMD_FRAME) begin
      if (it.safety_word[15:12] != STATUS_OK) begin
        r.status_error = 1'b1;
        if (shadow_status_errs != COUNT_MAX) shadow_status_errs++;
      end else if (sae_crc8(it.first_word, it.angle_word) != it.safety_word[7:0]) begin
        r.crc_error = 1'b1;
        if (shadow_crc_errs != COUNT_MAX) shadow_crc_errs++;
      end else begin
        r.angle       = it.angle_word[ANGLE_W-1:0];
        r.angle_valid = 1'b1;
      end
    end else begin
      r.error_rate = RATE_W'(shadow_status_errs) + RATE_W'(shadow_crc_errs);
      r.data_fault = shadow_fault_enable &&
                     (shadow_status_errs != '0 || shadow_crc_errs != '0) &&
                     (shadow_status_errs >= shadow_fault_limit ||
                      shadow_crc_errs >= shadow_fault_limit);
      shadow_status_errs = '0;
      shadow_crc_errs    = '0;
    end
    pending_results.push_back(r);
  endtask

  // Builds a frame whose CRC byte is the correct one xored with crc_flip.
  // The unused middle nibble of the safety word is random.
  function automatic in_item_t frame_of(input logic [WORD_W-1:0] w0,
                                        input logic [WORD_W-1:0] w1,
                                        input logic [3:0]        status,
                                        input logic [CRC_W-1:0]  crc_flip);
    in_item_t it;
    it.cmd         = CMD_FRAME;
    it.first_word  = w0;
    it.angle_word  = w1;
    it.safety_word = {status, 4'($urandom), sae_crc8(w0, w1) ^ crc_flip};
    return it;
  endfunction

  // A window tick carries random words, which the block must ignore.
  function automatic in_item_t tick_of();
    in_item_t it;
    it.cmd         = CMD_TICK;
    it.first_word  = WORD_W'($urandom);
    it.angle_word  = WORD_W'($urandom);
    it.safety_word = WORD_W'($urandom);
    return it;
  endfunction

  // Sends one item. The task is entered at a falling edge and returns at the
  // falling edge after acceptance with valid still high, so back-to-back
  // items never lower and raise valid in the same time step.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      frame_if.valid <= 1'b0;
      @(negedge clk);
    end
    frame_if.valid   <= 1'b1;
    frame_if.payload <= it;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    predict_result(it);
    @(negedge clk);
  endtask

  // Sends n failing frames of one kind with random content.
  task automatic send_errors(input int n, input err_kind_e kind);
    repeat (n) begin
      if (kind == ERR_STATUS) begin
        send_item(frame_of(WORD_W'($urandom), WORD_W'($urandom),
                           4'($urandom_range(0, 14)), CRC_W'($urandom)));
      end else begin
        send_item(frame_of(WORD_W'($urandom), WORD_W'($urandom),
                           STATUS_OK, CRC_W'($urandom_range(1, 255))));
      end
    end
  endtask

  // Drops valid and waits until the block has returned every result it owes.
  // Always advances at least one falling edge.
  task automatic drain_results();
    frame_if.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Register writes happen only with the block idle, so each one drains first.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{addr: idx, data: value};
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_FAULT_LIMIT:  shadow_fault_limit  = value;
      REG_FAULT_ENABLE: shadow_fault_enable = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Reset values of both registers. Fault reporting is off after reset, and
  // the default limit of 1000 sits far above the few errors counted here,
  // so no tick flags a fault even once reporting is switched on.
  task automatic test_reset_defaults();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    send_item(tick_of());
    send_errors(12, ERR_CRC);
    send_item(tick_of());
    write_reg(REG_FAULT_ENABLE, 16'h0001);
    send_errors(20, ERR_STATUS);
    send_errors(20, ERR_CRC);
    send_item(tick_of());
  endtask

  // Hand-picked frames: extreme words, several status failures, CRC faults in
  // single bits and the whole byte, and a limit of zero against empty counts.
  task automatic test_directed_frames();
    tx_gap_max   = MAX_GAP;
    rx_stall_max = MAX_GAP;
    send_item(frame_of(16'h0000, 16'h0000, STATUS_OK, 8'h00));
    // Angle bit 15 is not part of the angle and must be dropped.
    send_item(frame_of(16'hFFFF, 16'hFFFF, STATUS_OK, 8'h00));
    send_item(frame_of(16'h1234, 16'h7FFF, STATUS_OK, 8'h00));
    send_item(frame_of(16'hA5C3, 16'h8000, STATUS_OK, 8'h00));
    // Status nibble not all ones with a correct CRC: status error only.
    send_item(frame_of(16'h5A3C, 16'h2468, 4'h0, 8'h00));
    send_item(frame_of(16'hC0DE, 16'h1357, 4'h7, 8'h00));
    send_item(frame_of(16'h0F0F, 16'hF0F0, 4'hE, 8'h00));
    send_item(frame_of(16'h8001, 16'h4002, 4'hB, 8'h00));
    // Both checks fail: the CRC is not judged, so only a status error.
    send_item(frame_of(16'h3C3C, 16'h6996, 4'h0, 8'hFF));
    send_item(frame_of(16'h0001, 16'h0100, STATUS_OK, 8'h01));
    send_item(frame_of(16'h8000, 16'h0080, STATUS_OK, 8'h80));
    send_item(frame_of(16'hBEEF, 16'h7654, STATUS_OK, 8'hFF));
    // Five status errors and three CRC errors, below the limit of 1000.
    send_item(tick_of());
    write_reg(REG_FAULT_LIMIT, 16'h0000);
    write_reg(REG_FAULT_ENABLE, 16'h0001);
    // Nothing counted: no fault even though the limit is zero.
    send_item(tick_of());
    send_item(frame_of(16'h1111, 16'h2222, STATUS_OK, 8'h10));
    send_item(tick_of());
  endtask

  // Fault flag around the limit, with enable toggled through bit 0 only and
  // writes to unused indexes that must change nothing.
  task automatic test_fault_threshold();
    tx_gap_max   = MAX_GAP;
    rx_stall_max = MAX_GAP;
    write_reg(REG_FAULT_LIMIT, 16'd1);
    send_errors(1, ERR_CRC);
    send_item(tick_of());
    send_errors(1, ERR_STATUS);
    send_item(tick_of());
    write_reg(REG_FAULT_LIMIT, 16'd3);
    // Four errors in the window but neither count reaches three.
    send_errors(2, ERR_STATUS);
    send_errors(2, ERR_CRC);
    send_item(tick_of());
    send_errors(3, ERR_CRC);
    send_errors(1, ERR_STATUS);
    send_item(tick_of());
    // Upper data bits set, bit 0 clear: reporting goes off.
    write_reg(REG_FAULT_ENABLE, 16'hFFFE);
    send_errors(5, ERR_CRC);
    send_item(tick_of());
    write_reg(REG_FAULT_ENABLE, 16'hFFFF);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    send_errors(3, ERR_STATUS);
    send_item(tick_of());
    write_reg(REG_FAULT_LIMIT, 16'hFFFF);
    send_errors(7, ERR_CRC);
    send_item(tick_of());
  endtask

  // Mostly well-formed frames with random content, mixed with failing frames
  // and ticks. Each phase gets fresh register settings and one of four idling
  // patterns in turn; odd phases also hold the sender off mid-phase until the
  // block has returned everything.
  task automatic test_random_traffic();
    int unsigned              pick;
    logic [CFG_DATA_W-1:0]    limit_val;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       limit_val = 16'd1;
        1:       limit_val = COUNT_MAX;
        default: limit_val = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      write_reg(REG_FAULT_LIMIT, limit_val);
      write_reg(REG_FAULT_ENABLE, CFG_DATA_W'($urandom));
      case (phase % 4)
        0: begin
          tx_gap_max   = MAX_GAP;
          rx_stall_max = MAX_GAP;
        end
        1: begin
          tx_gap_max   = 0;
          rx_stall_max = 0;
        end
        2: begin
          tx_gap_max   = 0;
          rx_stall_max = MAX_GAP;
        end
        default: begin
          tx_gap_max   = MAX_GAP;
          rx_stall_max = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_item(frame_of(WORD_W'($urandom), WORD_W'($urandom), STATUS_OK, 8'h00));
        end else if (pick < 82) begin
          send_errors(1, ERR_STATUS);
        end else if (pick < 92) begin
          send_errors(1, ERR_CRC);
        end else begin
          send_item(tick_of());
        end
        if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 1) begin
          drain_results();
        end
      end
    end
  endtask

  // The receiver holds ready low for a random number of cycles after each
  // result it takes; a draw of zero keeps ready high.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      result_if.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest expected item.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got     = result_if.payload;
      rx_hold = $urandom_range(0, rx_stall_max);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("cycle %0d: unexpected angle=%h valid=%b serr=%b cerr=%b rate=%h fault=%b",
                   cycle_count, got.angle, got.angle_valid, got.status_error,
                   got.crc_error, got.error_rate, got.data_fault);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.angle !== want.angle || got.angle_valid !== want.angle_valid ||
            got.status_error !== want.status_error || got.crc_error !== want.crc_error ||
            got.error_rate !== want.error_rate || got.data_fault !== want.data_fault) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("cycle %0d: expected angle=%h valid=%b serr=%b cerr=%b rate=%h fault=%b",
                     cycle_count, want.angle, want.angle_valid, want.status_error,
                     want.crc_error, want.error_rate, want.data_fault);
            $display("cycle %0d: actual   angle=%h valid=%b serr=%b cerr=%b rate=%h fault=%b",
                     cycle_count, got.angle, got.angle_valid, got.status_error,
                     got.crc_error, got.error_rate, got.data_fault);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    frame_if.valid   = 1'b0;
    frame_if.payload = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.payload   = '0;
    result_if.ready  = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_frames();
    test_fault_threshold();
    test_random_traffic();

    // Let the pipeline settle after the last result before judging.
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
